// File: rtl/redundant_load_store_eliminator_core_macros.svh
// Assertion macros for the redundant load/store eliminator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef REDUNDANT_LOAD_STORE_ELIMINATOR_CORE_MACROS_SVH
`define REDUNDANT_LOAD_STORE_ELIMINATOR_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define RLSE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define RLSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rlse_pkg.sv
// Shared types and codes for the redundant load/store eliminator.
// No dependencies; imported by rlse_table and the top level.
package rlse_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    CMD_OTHER = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_STORE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_KEEP    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_DROP    = 2'd2
  } action_t;

  // One memory operation as it enters the table stage
  typedef struct packed {
    cmd_t               cmd;
    logic [FIELD_W-1:0] address_tag;
    logic [FIELD_W-1:0] value_tag;
    logic [FIELD_W-1:0] op_id;
    logic               skip;
  } item_t;

  // One result beat
  typedef struct packed {
    action_t            action;
    logic [FIELD_W-1:0] forward_tag;
    logic               kill_valid;
    logic [FIELD_W-1:0] kill_id;
    logic               no_room;
  } result_t;

endpackage

// File: rtl/rlse_table.sv
// Associative address table: parallel tag lookup, decision and update.
// Depends on rlse_pkg for item_t, result_t and the command/action codes.
module rlse_table import rlse_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int TAG_BITS      = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  // Tags are kept on their low TAG_BITS bits; ports carry at most FIELD_W bits
  localparam int SW = (TAG_BITS < FIELD_W) ? TAG_BITS : FIELD_W;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] has_store_r, has_store_nxt;
  logic [SW-1:0]            addr_r  [TABLE_ENTRIES];
  logic [SW-1:0]            value_r [TABLE_ENTRIES];
  logic [SW-1:0]            sid_r   [TABLE_ENTRIES];

  logic [SW-1:0]            addr_m, val_m, id_m;
  logic [TABLE_ENTRIES-1:0] hit_vec, free_vec, alloc_oh, alloc_we, update_we;
  logic                     hit, full;
  logic [SW-1:0]            hit_value, hit_sid;
  logic                     hit_has_store;
  logic                     is_access, is_store, same_value;

  assign addr_m = item.address_tag[SW-1:0];
  assign val_m  = item.value_tag[SW-1:0];
  assign id_m   = item.op_id[SW-1:0];

  // Compare every entry in parallel and fold the single hit onto one word
  always_comb begin
    hit_value     = '0;
    hit_sid       = '0;
    hit_has_store = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (addr_r[i] == addr_m);
      hit_value     = hit_value | (value_r[i] & {SW{hit_vec[i]}});
      hit_sid       = hit_sid | (sid_r[i] & {SW{hit_vec[i]}});
      hit_has_store = hit_has_store | (has_store_r[i] & hit_vec[i]);
    end
  end

  assign hit        = |hit_vec;
  assign same_value = (hit_value == val_m);

  // Lowest free entry as a one-hot vector
  assign free_vec = ~valid_r;
  assign alloc_oh = free_vec & (~free_vec + TABLE_ENTRIES'(1));
  assign full     = ~|free_vec;

  assign is_access = (item.cmd inside {CMD_LOAD, CMD_STORE}) && !item.skip;
  assign is_store  = (item.cmd == CMD_STORE) && !item.skip;

  // Build the result beat
  always_comb begin
    res = '0;
    res.action = ACT_KEEP;
    if (is_access) begin
      if (!hit) begin
        res.no_room = full;
      end else if (item.cmd == CMD_LOAD) begin
        res.action      = ACT_FORWARD;
        res.forward_tag = FIELD_W'(hit_value);
      end else if (same_value) begin
        res.action = ACT_DROP;
      end else begin
        res.kill_valid = hit_has_store;
        res.kill_id    = hit_has_store ? FIELD_W'(hit_sid) : '0;
      end
    end
  end

  // Write enables: allocate on a miss with room, update on a store hit with a new value
  assign alloc_we  = (fire && is_access && !hit) ? alloc_oh : '0;
  assign update_we = (fire && is_store && hit && !same_value) ? hit_vec : '0;

  always_comb begin
    valid_nxt     = valid_r | alloc_we;
    has_store_nxt = has_store_r | update_we;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (alloc_we[i]) begin
        has_store_nxt[i] = is_store;
      end
    end
    if (fire && item.cmd == CMD_CLEAR) begin
      valid_nxt     = '0;
      has_store_nxt = '0;
    end
  end

  // Hold the entry flags; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      has_store_r <= '0;
    end else begin
      valid_r     <= valid_nxt;
      has_store_r <= has_store_nxt;
    end
  end

  // Entry payload: address on allocation, value and store id on any write
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (alloc_we[i]) begin
        addr_r[i] <= addr_m;
      end
      if (alloc_we[i] || update_we[i]) begin
        value_r[i] <= val_m;
        sid_r[i]   <= id_m;
      end
    end
  end

endmodule

// File: rtl/redundant_load_store_eliminator_core.sv
// Redundant load/store eliminator, top level.
// Pipeline: input register, then result register, from input beat to result beat.
// Throughput: one beat per cycle unless out_ready stalls; the table lookup and update happen
// in the cycle an item moves from the input register to the result register.
// Reset (rst_n low, synchronous) empties the table and both registers at once.
`include "redundant_load_store_eliminator_core_macros.svh"
module redundant_load_store_eliminator_core import rlse_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int TAG_BITS      = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [FIELD_W-1:0] in_address_tag,
  input  logic [FIELD_W-1:0] in_value_tag,
  input  logic [FIELD_W-1:0] in_op_id,
  input  logic               in_skip,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic [FIELD_W-1:0] out_forward_tag,
  output logic               out_kill_valid,
  output logic [FIELD_W-1:0] out_kill_id,
  output logic               out_no_room
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t tbl_res;
  logic    in_fire, advance;

  // Move the held item on when the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input beat and the result beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.cmd         <= cmd_t'(in_command);
      s1_item_r.address_tag <= in_address_tag;
      s1_item_r.value_tag   <= in_value_tag;
      s1_item_r.op_id       <= in_op_id;
      s1_item_r.skip        <= in_skip;
    end
    if (advance) begin
      out_res_r <= tbl_res;
    end
  end

  rlse_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TAG_BITS      (TAG_BITS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .res   (tbl_res)
  );

  assign out_valid       = out_valid_r;
  assign out_action      = out_res_r.action;
  assign out_forward_tag = out_res_r.forward_tag;
  assign out_kill_valid  = out_res_r.kill_valid;
  assign out_kill_id     = out_res_r.kill_id;
  assign out_no_room     = out_res_r.no_room;

  // Checks on the pipeline and result encoding
  `RLSE_ASSERT_NEXT(a_accept_lands, in_fire, s1_valid_r, "accepted beat not held")
  `RLSE_ASSERT_NEXT(a_stall_holds, s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(s1_item_r), "held item lost under stall")
  `RLSE_ASSERT_IMPL(a_fwd_only, out_valid && out_action != ACT_FORWARD, out_forward_tag == '0, "forward tag without forward")
  `RLSE_ASSERT_IMPL(a_kill_keep, out_valid && out_kill_valid, out_action == ACT_KEEP && !out_no_room, "kill on non-keep beat")

endmodule
